/* sv/oaht_pkg.sv */
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared constants, codes and controller/datapath interface types for the
// open-address hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

    // default geometry
    localparam int unsigned CAPACITY_DEF  = 16;
    localparam int unsigned KEY_BYTES_DEF = 8;

    // 64-bit FNV-1a round, but with a non-standard offset basis
    localparam logic [63:0] FNV_OFFSET   = 64'd1469598103934665603;
    // prime = 2^40 + 0x1B3, split into a shift and a narrow multiply
    localparam int unsigned FNV_SHIFT    = 40;
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;

    // request codes
    localparam logic [1:0] CMD_GET = 2'd0;
    localparam logic [1:0] CMD_PUT = 2'd1;
    localparam logic [1:0] CMD_DEL = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture the request
        logic hash_step;   // hash one key byte
        logic probe_check; // evaluate the slot read back
        logic clear;       // clear one slot after reset
        logic finish;      // move the result into the output register
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic hash_done;
        logic bad_cmd;
        logic probe_end;
        logic clear_done;
        logic out_free;
    } t_stat;

endpackage

/* sv/open_address_hash_table.sv */
// After reset the block clears the slot table and takes no request until
// that is done. A request is then accepted, its key is hashed one byte at a
// time by the FNV-1a hasher, each slot probed is first read from the RAM and
// then compared and written, and the result is loaded into the output
// register. The probe walk through the single slot RAM visits from 1 to
// CAPACITY slots. An unknown command skips the probe walk. The output
// register load waits while the previous result is still held downstream.
// The next request is taken while a result still waits downstream.
// ----------------------------------------------------------------------------
// open_address_hash_table
// Open-addressing key/value table with FNV-1a hashing, triangular probing and
// tombstone removal; get, put and remove requests on a stream interface.
// ----------------------------------------------------------------------------
module open_address_hash_table #(
    parameter int unsigned CAPACITY  = oaht_pkg::CAPACITY_DEF,
    parameter int unsigned KEY_BYTES = oaht_pkg::KEY_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // command[1:0], key_bytes[65:2], key_length[69:66], new_value[101:70]
    input  logic [103:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // status[1:0], read_value[33:2], live_entries[38:34]
    output logic [39:0]  o_m_axis_tdata
);

    oaht_pkg::t_ctl  w_ctl;
    oaht_pkg::t_stat w_stat;
    logic [1:0]      w_status;
    logic [31:0]     w_read_value;
    logic [4:0]      w_live_entries;

    oaht_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (w_stat),
        .o_ctl           (w_ctl)
    );

    oaht_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_BYTES (KEY_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .o_stat          (w_stat),
        .i_command       (i_s_axis_tdata[1:0]),
        .i_key_bytes     (i_s_axis_tdata[65:2]),
        .i_key_length    (i_s_axis_tdata[69:66]),
        .i_new_value     (i_s_axis_tdata[101:70]),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_status        (w_status),
        .o_read_value    (w_read_value),
        .o_live_entries  (w_live_entries)
    );

    assign o_m_axis_tdata = {1'b0, w_live_entries, w_read_value, w_status};

endmodule

/* sv/oaht_ram.sv */
// ----------------------------------------------------------------------------
// oaht_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module oaht_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/oaht_ctrl.sv */
// ----------------------------------------------------------------------------
// oaht_ctrl
// Request sequencer: clearing pass, hashing, probe walk and result hand-off.
// ----------------------------------------------------------------------------
module oaht_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  oaht_pkg::t_stat i_stat,
    output oaht_pkg::t_ctl  o_ctl
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_ctl.clear = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                if (i_stat.hash_done) begin
                    n_state = i_stat.bad_cmd ? S_DONE : S_READ;
                end else begin
                    o_ctl.hash_step = 1'b1;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_ctl.probe_check = 1'b1;
                n_state = i_stat.probe_end ? S_DONE : S_READ;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_ctl.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);

    // a beat taken always starts a request
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_state == S_HASH))
        else $error("accepted beat did not start hashing");

endmodule

/* sv/oaht_dp.sv */
// ----------------------------------------------------------------------------
// oaht_dp
// Datapath: request registers, byte-serial FNV-1a, slot table RAM, probe
// evaluation, live count and the output register.
// ----------------------------------------------------------------------------
module oaht_dp #(
    parameter int unsigned CAPACITY  = oaht_pkg::CAPACITY_DEF,
    parameter int unsigned KEY_BYTES = oaht_pkg::KEY_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  oaht_pkg::t_ctl  i_ctl,
    output oaht_pkg::t_stat o_stat,
    input  logic [1:0]      i_command,
    input  logic [63:0]     i_key_bytes,
    input  logic [3:0]      i_key_length,
    input  logic [31:0]     i_new_value,
    input  logic            i_m_axis_tready,
    output logic            o_m_axis_tvalid,
    output logic [1:0]      o_status,
    output logic [31:0]     o_read_value,
    output logic [4:0]      o_live_entries
);

    localparam int unsigned IDX_W  = $clog2(CAPACITY);
    localparam int unsigned LIVE_W = $clog2(CAPACITY + 1);
    localparam int unsigned KEY_W  = 8 * KEY_BYTES;
    localparam int unsigned ENT_W  = KEY_W + 38;
    localparam logic [63:0] OFFSET = oaht_pkg::FNV_OFFSET;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    // request registers
    logic [1:0]       r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_kshift;
    logic [3:0]       r_len;
    logic [3:0]       r_cnt;
    logic [31:0]      r_val;
    logic [63:0]      r_hash;
    // probe state
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_step;
    logic             r_have_tomb;
    logic [IDX_W-1:0] r_tomb;
    logic [1:0]       r_res_status;
    logic [31:0]      r_res_rd;
    // table state
    logic [LIVE_W-1:0] r_live;
    logic [IDX_W-1:0]  r_clr;
    // output register
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [31:0] r_out_rd;
    logic [4:0]  r_out_live;

    logic [3:0]       w_len_eff;
    logic [KEY_W-1:0] w_key_trim;
    logic [63:0]      w_hash_x;
    logic [63:0]      w_hash_next;

    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [ENT_W-1:0] w_wdata;
    logic [ENT_W-1:0] w_rdata;

    logic             w_used;
    logic             w_removed;
    logic [3:0]       w_slot_len;
    logic [KEY_W-1:0] w_slot_key;
    logic [31:0]      w_slot_val;
    logic             w_match;
    logic             w_free;
    logic             w_last;
    logic             w_have_now;
    logic [IDX_W-1:0] w_tomb_now;
    logic             w_live_inc;
    logic             w_live_dec;
    logic [1:0]       w_status;
    logic [31:0]      w_live_ext;

    // clamp the length and drop bytes beyond it
    always_comb begin
        w_len_eff = (i_key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : i_key_length;
        for (int b = 0; b < KEY_BYTES; b++) begin
            w_key_trim[b*8 +: 8] = (4'(b) < w_len_eff) ? i_key_bytes[b*8 +: 8] : 8'h00;
        end
    end

    // one FNV-1a round: xor the byte, multiply by 2^40 + 0x1B3
    assign w_hash_x    = r_hash ^ {56'd0, r_kshift[7:0]};
    assign w_hash_next = (w_hash_x << oaht_pkg::FNV_SHIFT)
                       + (w_hash_x * {55'd0, oaht_pkg::FNV_PRIME_LO});

    // slot fields read back
    assign w_slot_val = w_rdata[31:0];
    assign w_slot_key = w_rdata[KEY_W+31:32];
    assign w_slot_len = w_rdata[KEY_W+35:KEY_W+32];
    assign w_removed  = w_rdata[KEY_W+36];
    assign w_used     = w_rdata[KEY_W+37];

    assign w_free     = !w_used;
    assign w_match    = w_used && !w_removed && (w_slot_len == r_len) && (w_slot_key == r_key);
    assign w_last     = (r_step == LAST_IDX);
    assign w_have_now = r_have_tomb || (w_used && w_removed);
    assign w_tomb_now = r_have_tomb ? r_tomb : r_idx;

    // probe decision and table write
    always_comb begin
        w_we       = 1'b0;
        w_waddr    = r_idx;
        w_wdata    = '0;
        w_live_inc = 1'b0;
        w_live_dec = 1'b0;
        w_status   = oaht_pkg::ST_MISS;
        if (i_ctl.clear) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
        end else if (i_ctl.probe_check) begin
            priority if (w_free) begin
                if (r_cmd == oaht_pkg::CMD_PUT) begin
                    w_we       = 1'b1;
                    w_waddr    = w_tomb_now;
                    w_wdata    = {1'b1, 1'b0, r_len, r_key, r_val};
                    w_live_inc = 1'b1;
                    w_status   = oaht_pkg::ST_OK;
                end
            end else if (w_match) begin
                w_status = oaht_pkg::ST_OK;
                if (r_cmd == oaht_pkg::CMD_PUT) begin
                    w_we    = 1'b1;
                    w_wdata = {1'b1, 1'b0, r_len, r_key, r_val};
                end else if (r_cmd == oaht_pkg::CMD_DEL) begin
                    w_we       = 1'b1;
                    w_wdata    = {1'b1, 1'b1, w_slot_len, w_slot_key, w_slot_val};
                    w_live_dec = 1'b1;
                end
            end else if (w_last && r_cmd == oaht_pkg::CMD_PUT) begin
                if (w_have_now) begin
                    w_we       = 1'b1;
                    w_waddr    = w_tomb_now;
                    w_wdata    = {1'b1, 1'b0, r_len, r_key, r_val};
                    w_live_inc = 1'b1;
                    w_status   = oaht_pkg::ST_OK;
                end else begin
                    w_status = oaht_pkg::ST_FULL;
                end
            end else begin
                w_status = oaht_pkg::ST_MISS;
            end
        end
    end

    oaht_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd        <= i_command;
            r_key        <= w_key_trim;
            r_kshift     <= w_key_trim;
            r_len        <= w_len_eff;
            r_cnt        <= '0;
            r_val        <= i_new_value;
            r_hash       <= OFFSET;
            r_idx        <= OFFSET[IDX_W-1:0];
            r_step       <= '0;
            r_have_tomb  <= 1'b0;
            r_tomb       <= '0;
            r_res_status <= oaht_pkg::ST_MISS;
            r_res_rd     <= '0;
        end else if (i_ctl.hash_step) begin
            r_hash   <= w_hash_next;
            r_idx    <= w_hash_next[IDX_W-1:0];
            r_kshift <= KEY_W'({8'd0, r_kshift} >> 8);
            r_cnt    <= r_cnt + 4'd1;
        end else if (i_ctl.probe_check) begin
            if (!r_have_tomb && w_used && w_removed) begin
                r_have_tomb <= 1'b1;
                r_tomb      <= r_idx;
            end
            r_idx        <= r_idx + r_step + IDX_W'(1);
            r_step       <= r_step + IDX_W'(1);
            r_res_status <= w_status;
            if (w_match && r_cmd == oaht_pkg::CMD_GET) begin
                r_res_rd <= w_slot_val;
            end
        end
        if (i_ctl.finish) begin
            r_out_status <= r_res_status;
            r_out_rd     <= r_res_rd;
            r_out_live   <= w_live_ext[4:0];
        end
    end

    assign w_live_ext = 32'(r_live);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_clr <= r_clr + IDX_W'(1);
            end
            if (w_live_inc) begin
                r_live <= r_live + LIVE_W'(1);
            end else if (w_live_dec) begin
                r_live <= r_live - LIVE_W'(1);
            end
            if (i_ctl.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.hash_done  = (r_cnt == r_len);
    assign o_stat.bad_cmd    = !(r_cmd == oaht_pkg::CMD_GET || r_cmd == oaht_pkg::CMD_PUT
                                 || r_cmd == oaht_pkg::CMD_DEL);
    assign o_stat.probe_end  = w_free || w_match || w_last;
    assign o_stat.clear_done = (r_clr == LAST_IDX);
    assign o_stat.out_free   = !r_out_valid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_status        = r_out_status;
    assign o_read_value    = r_out_rd;
    assign o_live_entries  = r_out_live;

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_live) <= CAPACITY)
        else $error("live count above capacity");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.finish |-> (!r_out_valid || i_m_axis_tready))
        else $error("result overwrote a pending beat");

    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (i_ctl.clear || i_ctl.probe_check))
        else $error("table written outside clear or probe check");

endmodule
